// ===== hw/rtl/dual_yaw_split_controller_unit_defines.svh =====
// Assertion macros shared by the dual yaw split controller RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef DUAL_YAW_SPLIT_CONTROLLER_UNIT_DEFINES_SVH
`define DUAL_YAW_SPLIT_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, masked during rst
`define DYSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, masked during rst
`define DYSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/dysc_pkg.sv =====
// Shared types and constants for the dual yaw split controller.
// No dependencies; imported by every module of the block.
package dysc_pkg;

  // Fixed-point format and angle constants (2pi and pi rounded to FRAC_BITS)
  localparam int     FRAC_BITS  = 16;
  localparam longint TWO_PI_Q32 = 64'sd26986075409;
  localparam longint PI_Q32     = 64'sd13493037705;
  localparam longint TWO_PI_Q   =
    (TWO_PI_Q32 + (longint'(1) << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam longint PI_Q       =
    (PI_Q32 + (longint'(1) << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

  // Modulo unit widths: signed input, biased unsigned value, quotient estimate
  localparam int     MOD_W    = $clog2(TWO_PI_Q);
  localparam int     ANG_W    = MOD_W + 1;
  localparam int     R_W      = MOD_W + 1;
  localparam int     X_W      = 34;
  localparam int     V_W      = X_W + 1;
  localparam longint MOD_BIAS =
    ((longint'(1) << (X_W - 1)) + TWO_PI_Q - 1) / TWO_PI_Q * TWO_PI_Q;
  localparam longint RECIP    = (longint'(1) << V_W) / TWO_PI_Q;
  localparam int     Q_W      = $clog2(RECIP + 1);

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QA_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  // Register map
  localparam int        IDX_W     = 4;
  localparam int        CFG_W     = 31;
  localparam logic [IDX_W-1:0] REG_UOFF = 4'd0;
  localparam logic [IDX_W-1:0] REG_LOFF = 4'd1;
  localparam logic [IDX_W-1:0] REG_HDB  = 4'd2;
  localparam logic [IDX_W-1:0] REG_LDB  = 4'd3;
  localparam logic [IDX_W-1:0] REG_RSM  = 4'd4;
  localparam logic [IDX_W-1:0] REG_UTM  = 4'd5;
  localparam logic [IDX_W-1:0] REG_LTM  = 4'd6;
  localparam logic [IDX_W-1:0] REG_MODE = 4'd7;
  localparam logic [17:0] UTM_RST = 18'd102944;
  localparam logic [30:0] LTM_RST = 31'h7FFF_FFFF;

  // Mode flag bits
  localparam int FLAG_UINV  = 0;
  localparam int FLAG_LINV  = 1;
  localparam int FLAG_UCONT = 2;
  localparam int FLAG_LCONT = 3;
  localparam int FLAG_CINV  = 4;

  typedef enum logic [1:0] {
    KIND_ENC = 2'd0,
    KIND_IMU = 2'd1,
    KIND_ABS = 2'd2,
    KIND_REL = 2'd3
  } kind_t;

  // Classified command as held in the queue
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] uenc;
    logic signed [31:0] lenc;
    logic signed [32:0] aux;   // imu heading, or signed heading argument
  } item_t;

  typedef struct packed {
    logic [18:0] uoff;
    logic [18:0] loff;
    logic [17:0] hdb;
    logic [17:0] ldb;
    logic [17:0] rsm;
    logic [17:0] utm;
    logic [30:0] ltm;
    logic [4:0]  flags;
  } cfg_t;

endpackage

// ===== hw/rtl/dual_yaw_split_controller_unit.sv =====
// Top level of the dual yaw split controller: register file, front, back.
// Depends on dysc_pkg, dysc_front and dysc_back.
//
//   channel | signals                                   | direction
//   in      | in_valid/in_ready, command + 4 angles     | beat in
//   out     | out_valid/out_ready, 2 targets + error    | beat out
//   cfg     | cfg_wr_en, cfg_index, cfg_data            | write only
//
// Update commands stream at one beat per cycle unless the queue or the output stalls;
// out_valid follows the accepting edge through the queue, two three-stage modulo-2pi
// units in series, two split stages and the output register.
// A relative set that follows another set waits until the first modulo unit
// has delivered the stored heading.
// Synchronous reset clears control state only; no clearing pass is needed.
// An output stall freezes the back pipeline; the four-entry queue keeps taking beats.
module dual_yaw_split_controller_unit import dysc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [31:0] upper_enc_pos,
  input  logic signed [31:0] lower_enc_pos,
  input  logic signed [31:0] imu_heading,
  input  logic signed [31:0] heading_arg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] upper_motor_target,
  output logic signed [31:0] lower_motor_target,
  output logic signed [18:0] heading_error,
  input  logic               cfg_wr_en,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  cfg_t  cfg;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.uoff  <= '0;
      cfg.loff  <= '0;
      cfg.hdb   <= '0;
      cfg.ldb   <= '0;
      cfg.rsm   <= '0;
      cfg.utm   <= UTM_RST;
      cfg.ltm   <= LTM_RST;
      cfg.flags <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_UOFF: cfg.uoff  <= cfg_data[18:0];
        REG_LOFF: cfg.loff  <= cfg_data[18:0];
        REG_HDB:  cfg.hdb   <= cfg_data[17:0];
        REG_LDB:  cfg.ldb   <= cfg_data[17:0];
        REG_RSM:  cfg.rsm   <= cfg_data[17:0];
        REG_UTM:  cfg.utm   <= cfg_data[17:0];
        REG_LTM:  cfg.ltm   <= cfg_data[30:0];
        REG_MODE: cfg.flags <= cfg_data[4:0];
        default:  cfg.flags <= cfg.flags;
      endcase
    end
  end

  dysc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .upper_enc_pos (upper_enc_pos),
    .lower_enc_pos (lower_enc_pos),
    .imu_heading   (imu_heading),
    .heading_arg   (heading_arg),
    .cmd_inv       (cfg.flags[FLAG_CINV]),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  dysc_back u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .upper_motor_target (upper_motor_target),
    .lower_motor_target (lower_motor_target),
    .heading_error      (heading_error)
  );

endmodule

// ===== hw/rtl/dysc_wrap.sv =====
// Three-stage exact reduction of a signed value modulo 2pi into [0, 2pi).
// Depends on dysc_pkg; used by dysc_back.
module dysc_wrap import dysc_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [X_W-1:0] x,
  output logic [MOD_W-1:0]      r
);

  logic signed [V_W:0]      xb;
  logic [V_W-1:0]           v1;
  logic [V_W-1:0]           v2;
  logic [Q_W-1:0]           q2;
  logic [R_W-1:0]           r3;
  logic [V_W+Q_W-1:0]       prod;
  logic [Q_W+MOD_W-1:0]     qm;
  logic [V_W-1:0]           diff;

  // bias by a multiple of 2pi so the value is non-negative
  assign xb   = (V_W+1)'(x) + (V_W+1)'(MOD_BIAS);
  // quotient estimate by reciprocal, low by at most one
  assign prod = {{Q_W{1'b0}}, v1} * (V_W+Q_W)'(RECIP);
  assign qm   = q2 * MOD_W'(TWO_PI_Q);
  assign diff = v2 - V_W'(qm);

  always_ff @(posedge clk) begin
    if (en) begin
      v1 <= xb[V_W-1:0];
      v2 <= v1;
      q2 <= prod[V_W+Q_W-1:V_W];
      r3 <= diff[R_W-1:0];
    end
  end

  // final correction: remainder lies in [0, 4pi)
  assign r = (r3 >= R_W'(TWO_PI_Q)) ? MOD_W'(r3 - R_W'(TWO_PI_Q)) : r3[MOD_W-1:0];

endmodule

// ===== hw/rtl/dysc_front.sv =====
// Front end: accepts command beats, classifies them and queues them.
// Depends on dysc_pkg and the assertion macro header.
`include "dual_yaw_split_controller_unit_defines.svh"
module dysc_front import dysc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [31:0] upper_enc_pos,
  input  logic signed [31:0] lower_enc_pos,
  input  logic signed [31:0] imu_heading,
  input  logic signed [31:0] heading_arg,
  input  logic               cmd_inv,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  item_t            mem [QDEPTH];
  item_t            cls;
  logic [QA_W-1:0]  wr_ptr;
  logic [QA_W-1:0]  rd_ptr;
  logic [QC_W-1:0]  count;
  logic             push;

  // classify: set commands carry the (optionally negated) argument
  always_comb begin
    cls.kind = kind_t'(command);
    cls.uenc = upper_enc_pos;
    cls.lenc = lower_enc_pos;
    if (cls.kind inside {KIND_ABS, KIND_REL}) begin
      cls.aux = cmd_inv ? -33'(heading_arg) : 33'(heading_arg);
    end else begin
      cls.aux = 33'(imu_heading);
    end
  end

  assign in_ready = (count != QC_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];

  // queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cls;
  end

  `DYSC_ASSERT_IMP(a_pop_nonempty, q_pop, count != '0, "queue popped while empty")
  `DYSC_ASSERT_IMP(a_fill_bound, 1'b1, count <= QC_W'(QDEPTH), "queue fill beyond depth")

endmodule

// ===== hw/rtl/dysc_back.sv =====
// Back end: wraps, splits the heading error and forms both motor targets.
// Depends on dysc_pkg, dysc_wrap and the assertion macro header.
`include "dual_yaw_split_controller_unit_defines.svh"
module dysc_back import dysc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] upper_motor_target,
  output logic signed [31:0] lower_motor_target,
  output logic signed [18:0] heading_error
);

  localparam int E_W = ANG_W + 4;
  localparam int O_W = 34;
  localparam int L_W = X_W + 3;

  typedef struct packed {
    kind_t                 kind;
    logic signed [31:0]    uenc;
    logic signed [31:0]    lenc;
    logic signed [32:0]    aux;
    logic signed [X_W-1:0] l;
  } a_side_t;

  typedef struct packed {
    logic signed [31:0]      uenc;
    logic signed [31:0]      lenc;
    logic signed [ANG_W-1:0] u;
    logic signed [X_W-1:0]   l;
  } b_side_t;

  logic              adv, issue, hazard, set_busy;
  logic [MOD_W-1:0]  ht;
  logic              a_v [3];
  a_side_t           a_s [3];
  logic              b_v [3];
  b_side_t           b_s [3];
  a_side_t           a_in;

  logic signed [X_W-1:0] uoff_x, loff_x, ht_x, pi_x, ud, ld, xu, xs, wa_x, xe;
  logic [MOD_W-1:0]      ra, rb;
  logic                  a3_set;
  logic signed [ANG_W-1:0] u_a, err_w, err_db, ww, lstep0, rsm_s, hdb_s;
  logic signed [ANG_W:0]   w;

  // stage C1 / C2 registers
  logic                    c1_v, c2_v;
  logic signed [ANG_W-1:0] c1_err, c1_u, c1_lstep;
  logic signed [X_W-1:0]   c1_l, c2_l;
  logic signed [31:0]      c1_uenc, c1_lenc, c2_lenc, c2_umot;
  logic signed [ANG_W-1:0] c2_err;
  logic signed [E_W-1:0]   c2_lst;

  logic signed [E_W-1:0] udiff0, utgt, utgt_c, udiff, lst, utm_s;
  logic signed [O_W-1:0] umot;
  logic signed [31:0]    umot_sat, lmot_sat;
  logic signed [L_W-1:0] s, sc, lstep, lstep_db, lmot, ltm_s, ldb_s;

  // whole back pipeline moves when the output register can take a beat
  assign adv      = !out_valid || out_ready;
  assign set_busy = (a_v[0] && (a_s[0].kind inside {KIND_ABS, KIND_REL})) ||
                    (a_v[1] && (a_s[1].kind inside {KIND_ABS, KIND_REL})) ||
                    (a_v[2] && (a_s[2].kind inside {KIND_ABS, KIND_REL}));
  assign hazard   = (q_item.kind == KIND_REL) && set_busy;
  assign issue    = q_valid && adv && !hazard;
  assign q_pop    = issue;

  // issue: joint angles and first wrap operand
  assign uoff_x = X_W'(signed'({1'b0, cfg.uoff}));
  assign loff_x = X_W'(signed'({1'b0, cfg.loff}));
  assign ht_x   = X_W'(signed'({1'b0, ht}));
  assign pi_x   = X_W'(PI_Q);
  assign ud     = X_W'(q_item.uenc) - uoff_x;
  assign ld     = X_W'(q_item.lenc) - loff_x;
  assign xu     = (cfg.flags[FLAG_UINV] ? -ud : ud) + pi_x;
  assign xs     = (q_item.kind == KIND_ABS) ? X_W'(q_item.aux) + uoff_x
                                             : X_W'(q_item.aux) + ht_x;
  assign wa_x   = (q_item.kind inside {KIND_ABS, KIND_REL}) ? xs : xu;

  always_comb begin
    a_in.kind = q_item.kind;
    a_in.uenc = q_item.uenc;
    a_in.lenc = q_item.lenc;
    a_in.aux  = q_item.aux;
    a_in.l    = cfg.flags[FLAG_LINV] ? -ld : ld;
  end

  dysc_wrap u_wrap_a (.clk(clk), .en(adv), .x(wa_x), .r(ra));

  // after first wrap: store set target, or form heading error operand
  assign a3_set = a_s[2].kind inside {KIND_ABS, KIND_REL};
  assign u_a    = signed'({1'b0, ra}) - ANG_W'(PI_Q);
  assign xe     = (a_s[2].kind == KIND_ENC)
                ? ht_x - uoff_x + pi_x - (X_W'(u_a) + a_s[2].l)
                : ht_x - uoff_x + pi_x - X_W'(a_s[2].aux);

  dysc_wrap u_wrap_b (.clk(clk), .en(adv), .x(xe), .r(rb));

  // after second wrap: deadband and recentering step
  assign hdb_s  = signed'(ANG_W'(cfg.hdb));
  assign rsm_s  = signed'(ANG_W'(cfg.rsm));
  assign err_w  = signed'({1'b0, rb}) - ANG_W'(PI_Q);
  assign err_db = (err_w < hdb_s && err_w > -hdb_s) ? '0 : err_w;
  assign w      = (ANG_W+1)'(b_s[2].u) + (ANG_W+1)'(err_db);

  always_comb begin
    if (w < -(ANG_W+1)'(PI_Q)) begin
      ww = ANG_W'(w + (ANG_W+1)'(TWO_PI_Q));
    end else if (w >= (ANG_W+1)'(TWO_PI_Q - PI_Q)) begin
      ww = ANG_W'(w - (ANG_W+1)'(TWO_PI_Q));
    end else begin
      ww = ANG_W'(w);
    end
    if (cfg.rsm == '0) begin
      lstep0 = '0;
    end else if (ww > rsm_s) begin
      lstep0 = rsm_s;
    end else if (ww < -rsm_s) begin
      lstep0 = -rsm_s;
    end else begin
      lstep0 = ww;
    end
  end

  // stage C1: upper joint target within its travel
  assign utm_s  = signed'(E_W'(cfg.utm));
  assign udiff0 = E_W'(c1_err) - E_W'(c1_lstep);
  assign utgt   = E_W'(c1_u) + udiff0;

  always_comb begin
    if (cfg.flags[FLAG_UCONT]) begin
      utgt_c = utgt;
    end else if (utgt > utm_s) begin
      utgt_c = utm_s;
    end else if (utgt < -utm_s) begin
      utgt_c = -utm_s;
    end else begin
      utgt_c = utgt;
    end
  end

  assign udiff    = utgt_c - E_W'(c1_u);
  assign umot     = O_W'(c1_uenc) + (cfg.flags[FLAG_UINV] ? -O_W'(udiff) : O_W'(udiff));
  assign umot_sat = (umot[O_W-1:31] == '0 || umot[O_W-1:31] == '1) ? umot[31:0]
                  : (umot[O_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
  assign lst      = E_W'(c1_err) - udiff;

  // stage C2: lower joint absorbs the rest within its travel and deadband
  assign ltm_s = signed'(L_W'(cfg.ltm));
  assign ldb_s = signed'(L_W'(cfg.ldb));
  assign s     = L_W'(c2_l) + L_W'(c2_lst);

  always_comb begin
    if (cfg.flags[FLAG_LCONT]) begin
      sc = s;
    end else if (s > ltm_s) begin
      sc = ltm_s;
    end else if (s < -ltm_s) begin
      sc = -ltm_s;
    end else begin
      sc = s;
    end
  end

  assign lstep    = cfg.flags[FLAG_LCONT] ? L_W'(c2_lst) : sc - L_W'(c2_l);
  assign lstep_db = (lstep < ldb_s && lstep > -ldb_s) ? '0 : lstep;
  assign lmot     = L_W'(c2_lenc) + (cfg.flags[FLAG_LINV] ? -lstep_db : lstep_db);
  assign lmot_sat = (lmot[L_W-1:31] == '0 || lmot[L_W-1:31] == '1) ? lmot[31:0]
                  : (lmot[L_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  // valid bits and heading target
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v[0]    <= 1'b0;
      a_v[1]    <= 1'b0;
      a_v[2]    <= 1'b0;
      b_v[0]    <= 1'b0;
      b_v[1]    <= 1'b0;
      b_v[2]    <= 1'b0;
      c1_v      <= 1'b0;
      c2_v      <= 1'b0;
      out_valid <= 1'b0;
      ht        <= '0;
    end else if (adv) begin
      a_v[0]    <= issue;
      a_v[1]    <= a_v[0];
      a_v[2]    <= a_v[1];
      b_v[0]    <= a_v[2] && !a3_set;
      b_v[1]    <= b_v[0];
      b_v[2]    <= b_v[1];
      c1_v      <= b_v[2];
      c2_v      <= c1_v;
      out_valid <= c2_v;
      if (a_v[2] && a3_set) ht <= ra;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      a_s[0]      <= a_in;
      a_s[1]      <= a_s[0];
      a_s[2]      <= a_s[1];
      b_s[0].uenc <= a_s[2].uenc;
      b_s[0].lenc <= a_s[2].lenc;
      b_s[0].u    <= u_a;
      b_s[0].l    <= a_s[2].l;
      b_s[1]      <= b_s[0];
      b_s[2]      <= b_s[1];
      c1_err      <= err_db;
      c1_u        <= b_s[2].u;
      c1_l        <= b_s[2].l;
      c1_lstep    <= lstep0;
      c1_uenc     <= b_s[2].uenc;
      c1_lenc     <= b_s[2].lenc;
      c2_err      <= c1_err;
      c2_umot     <= umot_sat;
      c2_lst      <= lst;
      c2_l        <= c1_l;
      c2_lenc     <= c1_lenc;
      upper_motor_target <= c2_umot;
      lower_motor_target <= lmot_sat;
      heading_error      <= c2_err[18:0];
    end
  end

  `DYSC_ASSERT_IMP(a_rel_order, issue && q_item.kind == KIND_REL, !set_busy,
                   "relative set issued past a pending set")
  `DYSC_ASSERT_IMP(a_target_range, 1'b1, ht < MOD_W'(TWO_PI_Q),
                   "heading target outside one turn")
  `DYSC_ASSERT_IMP(a_err_range, out_valid,
                   heading_error >= -19'(PI_Q) && heading_error <= 19'(PI_Q),
                   "heading error outside half a turn")

endmodule
